// ----- rtl/tps_pkg.sv -----
// Shared constants and types for the triangle perimeter sorter.
package tps_pkg;

    localparam int MaxItemsDefault = 16;
    localparam int TagW    = 8;
    localparam int CoordW  = 16;
    localparam int PerimW  = 19;
    localparam int DiffW   = 17;
    localparam int SqW     = 34;
    localparam int RootW   = 17;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_STORE,
        ST_SORT,
        ST_EMIT
    } state_t;

    // Control word that goes to every cell of the sort chain.
    typedef struct packed {
        logic load;    // write the new entry at the tail
        logic sweep;   // odd-even compare/exchange step
        logic odd;     // which pair phase of the sweep
        logic shift;   // move entries toward cell 0 for output
    } cell_ctrl_t;

endpackage

// ----- rtl/triangle_perimeter_sorter.sv -----
// Top level: perimeter unit, odd-even transposition chain, output sequencer.
//
//  channel | signals                                   | direction
//  command | start, busy, item_tag, *_x, *_y, set_end  | in (busy is out)
//  result  | valid, out_tag, out_perimeter, out_last,  | out
//          | dropped                                   |
//
// Each of the three roots takes one start step plus 17 root-bit steps, and a
// store step follows the third root.
// The word with set_end adds MAX_ITEMS compare/exchange sweeps in the chain,
// then one result per cycle for every stored entry.
// busy is high from the cycle after acceptance through store, or the last result.
// rst_n clears control state; stored entries are undefined until written.
// The receiver cannot stall; results appear on consecutive cycles.
module triangle_perimeter_sorter
#(
    parameter int MAX_ITEMS = tps_pkg::MaxItemsDefault
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tps_pkg::TagW-1:0]      item_tag,
    input  logic signed [tps_pkg::CoordW-1:0] first_x,
    input  logic signed [tps_pkg::CoordW-1:0] first_y,
    input  logic signed [tps_pkg::CoordW-1:0] second_x,
    input  logic signed [tps_pkg::CoordW-1:0] second_y,
    input  logic signed [tps_pkg::CoordW-1:0] third_x,
    input  logic signed [tps_pkg::CoordW-1:0] third_y,
    input  logic                          set_end,
    output logic                          valid,
    output logic [tps_pkg::TagW-1:0]      out_tag,
    output logic [tps_pkg::PerimW-1:0]    out_perimeter,
    output logic                          out_last,
    output logic                          dropped
);

    localparam int CountW = $clog2(MAX_ITEMS + 1);
    localparam int DiffW = tps_pkg::DiffW;

    tps_pkg::state_t state_reg, state_next;
    tps_pkg::cell_ctrl_t ctrl;

    logic signed [tps_pkg::CoordW-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic [tps_pkg::TagW-1:0] tag_in_reg;
    logic end_reg;
    logic [1:0] edge_reg, edge_next;
    logic [tps_pkg::PerimW-1:0] sum_reg, sum_next;
    logic [CountW-1:0] count_reg, count_next;
    logic [CountW-1:0] pass_reg, pass_next;
    logic over_reg, over_next;
    logic odd_reg, odd_next;
    logic rs_reg, rs_next;

    logic accept;
    logic root_start, root_done;
    logic [tps_pkg::RootW-1:0] root;
    logic signed [tps_pkg::DiffW-1:0] dx, dy;
    logic [tps_pkg::DiffW-2:0] ux, uy;
    logic [2*(tps_pkg::DiffW-1)-1:0] sq_x, sq_y;
    logic [tps_pkg::SqW-1:0] radicand;
    logic full;

    logic [tps_pkg::PerimW-1:0] cell_perim [MAX_ITEMS];
    logic [tps_pkg::TagW-1:0]   cell_tag   [MAX_ITEMS];

    assign accept = start && !busy;
    assign full   = (count_reg == CountW'(MAX_ITEMS));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg <= first_x;  ay_reg <= first_y;
            bx_reg <= second_x; by_reg <= second_y;
            cx_reg <= third_x;  cy_reg <= third_y;
            tag_in_reg <= item_tag;
            end_reg <= set_end;
        end
    end

    // Pick the edge endpoints for the current root pass.
    always_comb
    begin
        unique case (edge_reg)
            2'd0:
            begin
                dx = DiffW'(bx_reg) - DiffW'(ax_reg);
                dy = DiffW'(by_reg) - DiffW'(ay_reg);
            end
            2'd1:
            begin
                dx = DiffW'(cx_reg) - DiffW'(bx_reg);
                dy = DiffW'(cy_reg) - DiffW'(by_reg);
            end
            default:
            begin
                dx = DiffW'(ax_reg) - DiffW'(cx_reg);
                dy = DiffW'(ay_reg) - DiffW'(cy_reg);
            end
        endcase
    end

    assign ux = dx[DiffW-1] ? (DiffW-1)'(-dx) : (DiffW-1)'(dx);
    assign uy = dy[DiffW-1] ? (DiffW-1)'(-dy) : (DiffW-1)'(dy);
    // 16x16 squares; the sum of two fits 33 bits.
    assign sq_x = ux * ux;
    assign sq_y = uy * uy;
    assign radicand = tps_pkg::SqW'(sq_x) + tps_pkg::SqW'(sq_y);

    tps_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tps_pkg::ST_IDLE:  if (accept) state_next = tps_pkg::ST_ROOT;
            tps_pkg::ST_ROOT:  if (root_done && edge_reg == 2'd2)
                                   state_next = tps_pkg::ST_STORE;
            tps_pkg::ST_STORE:
                if (!end_reg)
                    state_next = tps_pkg::ST_IDLE;
                else
                    state_next = tps_pkg::ST_SORT;
            tps_pkg::ST_SORT:  if (pass_reg == '0) state_next = tps_pkg::ST_EMIT;
            tps_pkg::ST_EMIT:  if (count_reg == CountW'(1)) state_next = tps_pkg::ST_IDLE;
            default:           state_next = tps_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath control.
    always_comb
    begin
        edge_next  = edge_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        pass_next  = pass_reg;
        over_next  = over_reg;
        odd_next   = odd_reg;
        ctrl       = '0;
        unique case (state_reg)
            tps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    edge_next = 2'd0;
                    sum_next  = '0;
                end
            end
            tps_pkg::ST_ROOT:
            begin
                if (root_done)
                begin
                    sum_next  = sum_reg + tps_pkg::PerimW'(root);
                    edge_next = edge_reg + 2'd1;
                end
            end
            tps_pkg::ST_STORE:
            begin
                if (full)
                    over_next = 1'b1;
                else
                begin
                    ctrl.load  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                pass_next = CountW'(MAX_ITEMS);
                odd_next  = 1'b0;
            end
            tps_pkg::ST_SORT:
            begin
                if (pass_reg != '0)
                begin
                    ctrl.sweep = 1'b1;
                    ctrl.odd   = odd_reg;
                    odd_next   = !odd_reg;
                    pass_next  = pass_reg - 1'b1;
                end
            end
            tps_pkg::ST_EMIT:
            begin
                ctrl.shift = 1'b1;
                count_next = count_reg - 1'b1;
                if (count_reg == CountW'(1))
                    over_next = 1'b0;
            end
            default: ;
        endcase
    end

    // Kick the root unit once per edge: on entry to ROOT and after each done but the last.
    assign rs_next = (accept) || (state_reg == tps_pkg::ST_ROOT && root_done
                                  && edge_reg != 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tps_pkg::ST_IDLE;
            count_reg <= '0;
            over_reg  <= 1'b0;
            pass_reg  <= '0;
            odd_reg   <= 1'b0;
            edge_reg  <= 2'd0;
            rs_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            over_reg  <= over_next;
            pass_reg  <= pass_next;
            odd_reg   <= odd_next;
            edge_reg  <= edge_next;
            rs_reg    <= rs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            logic [tps_pkg::PerimW-1:0] lo_p, hi_p;
            logic [tps_pkg::TagW-1:0] lo_t, hi_t;
            logic lo_v, hi_v;
            if (gi == 0)
            begin : g_lo0
                assign lo_p = '0; assign lo_t = '0; assign lo_v = 1'b0;
            end
            else
            begin : g_lo
                assign lo_p = cell_perim[gi-1]; assign lo_t = cell_tag[gi-1];
                assign lo_v = (CountW'(gi) < count_reg);
            end
            if (gi == MAX_ITEMS-1)
            begin : g_hiN
                assign hi_p = cell_perim[gi]; assign hi_t = cell_tag[gi];
                assign hi_v = 1'b0;
            end
            else
            begin : g_hi
                assign hi_p = cell_perim[gi+1]; assign hi_t = cell_tag[gi+1];
                assign hi_v = (CountW'(gi+1) < count_reg);
            end
            tps_cell u_cell
            (
                .clk       (clk),
                .ctrl      (ctrl),
                .is_tail   (count_reg == CountW'(gi)),
                .even_pos  ((gi % 2) == 0),
                .new_perim (sum_reg),
                .new_tag   (tag_in_reg),
                .lo_perim  (lo_p),
                .lo_tag    (lo_t),
                .lo_valid  (lo_v),
                .hi_perim  (hi_p),
                .hi_tag    (hi_t),
                .hi_valid  (hi_v),
                .perim     (cell_perim[gi]),
                .tag       (cell_tag[gi])
            );
        end
    endgenerate

    assign busy          = (state_reg != tps_pkg::ST_IDLE);
    assign valid         = (state_reg == tps_pkg::ST_EMIT);
    assign out_tag       = cell_tag[0];
    assign out_perimeter = cell_perim[0];
    assign out_last      = valid && (count_reg == CountW'(1));
    assign dropped       = over_reg;

    assign root_start = rs_reg;

    a_last_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_last |=> !valid)
        else $error("results continue after last word");
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (count_reg != '0))
        else $error("emit with empty store");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountW'(MAX_ITEMS))
        else $error("entry count beyond capacity");

endmodule

// ----- rtl/tps_isqrt.sv -----
// Bit-serial floor square root: one root bit per cycle.
module tps_isqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tps_pkg::SqW-1:0]       radicand,
    output logic                          done,
    output logic [tps_pkg::RootW-1:0]     root
);

    localparam int Steps = tps_pkg::SqW / 2;
    localparam int CntW  = $clog2(Steps + 1);

    logic [tps_pkg::SqW-1:0] rem_reg, rem_next;
    logic [tps_pkg::SqW-1:0] val_reg, val_next;
    logic [tps_pkg::RootW-1:0] root_reg, root_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [tps_pkg::SqW-1:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        val_next  = val_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[tps_pkg::SqW-3:0], val_reg[tps_pkg::SqW-1 -: 2]}
              - {{(tps_pkg::SqW-tps_pkg::RootW-2){1'b0}}, root_reg, 2'b01};
        if (start)
        begin
            rem_next  = '0;
            val_next  = radicand;
            root_next = '0;
            cnt_next  = CntW'(Steps);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[tps_pkg::SqW-3:0], 2'b00};
            if ({rem_reg[tps_pkg::SqW-3:0], val_reg[tps_pkg::SqW-1 -: 2]} >=
                {{(tps_pkg::SqW-tps_pkg::RootW-2){1'b0}}, root_reg, 2'b01})
            begin
                rem_next  = trial;
                root_next = {root_reg[tps_pkg::RootW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[tps_pkg::SqW-3:0], val_reg[tps_pkg::SqW-1 -: 2]};
                root_next = {root_reg[tps_pkg::RootW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        val_reg  <= val_next;
        root_reg <= root_next;
    end

    assign done = busy_reg && (cnt_reg == CntW'(1));
    assign root = root_next;

endmodule

// ----- rtl/tps_cell.sv -----
// One cell of the sort chain: holds one entry, swaps with its upper or lower neighbor by phase.
module tps_cell
(
    input  logic                           clk,
    input  tps_pkg::cell_ctrl_t            ctrl,
    input  logic                           is_tail,
    input  logic                           even_pos,
    input  logic [tps_pkg::PerimW-1:0]     new_perim,
    input  logic [tps_pkg::TagW-1:0]       new_tag,
    input  logic [tps_pkg::PerimW-1:0]     lo_perim,
    input  logic [tps_pkg::TagW-1:0]       lo_tag,
    input  logic                           lo_valid,
    input  logic [tps_pkg::PerimW-1:0]     hi_perim,
    input  logic [tps_pkg::TagW-1:0]       hi_tag,
    input  logic                           hi_valid,
    output logic [tps_pkg::PerimW-1:0]     perim,
    output logic [tps_pkg::TagW-1:0]       tag
);

    logic [tps_pkg::PerimW-1:0] perim_reg, perim_next;
    logic [tps_pkg::TagW-1:0]   tag_reg, tag_next;
    logic lower_of_pair;

    // Pair (i,i+1) is active when i parity matches the phase.
    assign lower_of_pair = (even_pos != ctrl.odd);

    always_comb
    begin
        perim_next = perim_reg;
        tag_next   = tag_reg;
        if (ctrl.load && is_tail)
        begin
            perim_next = new_perim;
            tag_next   = new_tag;
        end
        else if (ctrl.sweep)
        begin
            if (lower_of_pair && hi_valid && (perim_reg > hi_perim))
            begin
                perim_next = hi_perim;
                tag_next   = hi_tag;
            end
            else if (!lower_of_pair && lo_valid && (lo_perim > perim_reg))
            begin
                perim_next = lo_perim;
                tag_next   = lo_tag;
            end
        end
        else if (ctrl.shift)
        begin
            perim_next = hi_perim;
            tag_next   = hi_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        perim_reg <= perim_next;
        tag_reg   <= tag_next;
    end

    assign perim = perim_reg;
    assign tag   = tag_reg;

endmodule

// ----- dv/tb_triangle_perimeter_sorter.sv -----
// Testbench for the triangle perimeter sorter: perimeter, stable sort, overflow.
module tb_triangle_perimeter_sorter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TagW   = tps_pkg::TagW;
    localparam int CoordW = tps_pkg::CoordW;
    localparam int PerimW = tps_pkg::PerimW;
    localparam int DiffW  = tps_pkg::DiffW;
    localparam int SqW    = tps_pkg::SqW;
    localparam int RootW  = tps_pkg::RootW;

    localparam int Depth = tps_pkg::MaxItemsDefault;
    localparam int WatchdogLimit = 20000;

    typedef struct packed {
        logic [TagW-1:0]   tag;
        logic [PerimW-1:0] perim;
        logic              last;
        logic              drop;
    } sorted_word_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [TagW-1:0] item_tag;
    logic signed [CoordW-1:0] first_x, first_y, second_x, second_y, third_x, third_y;
    logic set_end;
    logic valid;
    logic [TagW-1:0] out_tag;
    logic [PerimW-1:0] out_perimeter;
    logic out_last;
    logic dropped;

    // predictor state
    logic [PerimW-1:0] held_perim[Depth];
    logic [TagW-1:0]   held_tag[Depth];
    int                held_count;
    bit                held_overflow;

    sorted_word_t expected_words[$];
    int  error_count;
    int  idle_cycles;
    bit  timed_out;

    triangle_perimeter_sorter i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .item_tag(item_tag), .first_x(first_x), .first_y(first_y),
        .second_x(second_x), .second_y(second_y), .third_x(third_x),
        .third_y(third_y), .set_end(set_end), .valid(valid),
        .out_tag(out_tag), .out_perimeter(out_perimeter),
        .out_last(out_last), .dropped(dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [RootW-1:0] floor_root(logic [SqW-1:0] v);
        logic [35:0] rem;
        logic [35:0] root;
        logic [35:0] bitv;
        rem  = 36'(v);
        root = '0;
        bitv = 36'h1 << 34;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root[RootW-1:0];
    endfunction

    function automatic logic [RootW-1:0] edge_length(logic signed [CoordW-1:0] ax,
            logic signed [CoordW-1:0] ay, logic signed [CoordW-1:0] bx,
            logic signed [CoordW-1:0] by);
        logic signed [DiffW-1:0] dx;
        logic signed [DiffW-1:0] dy;
        logic [DiffW-1:0] mx;
        logic [DiffW-1:0] my;
        dx = DiffW'(bx) - DiffW'(ax);
        dy = DiffW'(by) - DiffW'(ay);
        mx = dx[DiffW-1] ? -dx : dx;
        my = dy[DiffW-1] ? -dy : dy;
        return floor_root(SqW'(mx) * SqW'(mx) + SqW'(my) * SqW'(my));
    endfunction

    // Store one triangle; on set end sort stably and queue the run.
    task automatic predict_sorted_run(logic [TagW-1:0] tg, logic signed [CoordW-1:0] c[6],
            logic fin);
        logic [PerimW-1:0] p;
        logic [PerimW-1:0] tp;
        logic [TagW-1:0] tt;
        sorted_word_t w;
        p = PerimW'(edge_length(c[0], c[1], c[2], c[3]))
          + PerimW'(edge_length(c[2], c[3], c[4], c[5]))
          + PerimW'(edge_length(c[4], c[5], c[0], c[1]));
        if (held_count < Depth)
        begin
            held_perim[held_count] = p;
            held_tag[held_count] = tg;
            held_count++;
        end
        else
            held_overflow = 1'b1;
        if (!fin)
            return;
        for (int i = 1; i < held_count; i++)
            for (int j = 0; j < held_count - i; j++)
                if (held_perim[j] > held_perim[j+1])
                begin
                    tp = held_perim[j]; held_perim[j] = held_perim[j+1]; held_perim[j+1] = tp;
                    tt = held_tag[j];   held_tag[j] = held_tag[j+1];     held_tag[j+1] = tt;
                end
        for (int i = 0; i < held_count; i++)
        begin
            w.tag = held_tag[i];
            w.perim = held_perim[i];
            w.last = (i == held_count - 1);
            w.drop = held_overflow;
            expected_words.push_back(w);
        end
        held_count = 0;
        held_overflow = 1'b0;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // check each result word against the oldest expectation
    always @(posedge clk)
    begin
        sorted_word_t w;
        if (rst_n && valid)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, tag", out_tag, -1);
            else
            begin
                w = expected_words.pop_front();
                if (out_tag !== w.tag) report_mismatch("out_tag", out_tag, w.tag);
                if (out_perimeter !== w.perim)
                    report_mismatch("out_perimeter", out_perimeter, w.perim);
                if (out_last !== w.last) report_mismatch("out_last", out_last, w.last);
                if (dropped !== w.drop) report_mismatch("dropped", dropped, w.drop);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || valid || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WatchdogLimit);
        timed_out = 1'b1;
        $display("Regression FAIL");
        $finish;
    end

    // Drive at the falling edge once busy is low, so the next rising edge accepts.
    task automatic send_triangle(logic [TagW-1:0] tg, logic signed [CoordW-1:0] c[6],
            logic fin);
        int gap;
        gap = $urandom_range(0, 9);
        repeat (gap) @(negedge clk);
        while (busy) @(negedge clk);
        item_tag = tg;
        first_x = c[0]; first_y = c[1];
        second_x = c[2]; second_y = c[3];
        third_x = c[4]; third_y = c[5];
        set_end = fin;
        start = 1'b1;
        @(posedge clk);
        predict_sorted_run(tg, c, fin);
        @(negedge clk);
        start = 1'b0;
    endtask

    function automatic logic signed [CoordW-1:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return CoordW'($urandom_range(0, 64)) - 16'sd32;
            default: return CoordW'($urandom);
        endcase
    endfunction

    task automatic send_random_triangle(logic fin);
        logic signed [CoordW-1:0] c[6];
        foreach (c[k]) c[k] = rand_coord();
        send_triangle(TagW'($urandom), c, fin);
    endtask

    task automatic drain_results();
        while (expected_words.size() != 0) @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic test_extremes();
        logic signed [CoordW-1:0] c[6];
        // degenerate, then widest span on every edge, then a right triangle ending the run
        c = '{default: 16'sd0};
        send_triangle(8'd0, c, 1'b0);
        c = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff};
        send_triangle(8'hff, c, 1'b0);
        c = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_triangle(8'h5a, c, 1'b0);
        c = '{16'sd0, 16'sd0, 16'sd768, 16'sd0, 16'sd0, 16'sd1024};
        send_triangle(8'ha5, c, 1'b1);
        // single-entry run
        c = '{16'sd256, 16'sd256, -16'sd256, 16'sd256, 16'sd0, -16'sd256};
        send_triangle(8'h11, c, 1'b1);
        drain_results();
    endtask

    task automatic test_stable_ties();
        logic signed [CoordW-1:0] c[6];
        c = '{16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0, 16'sd100};
        for (int i = 0; i < 5; i++)
            send_triangle(TagW'(i + 1), c, i == 4);
        drain_results();
    endtask

    task automatic test_overflow();
        // full store, then extra items, the last with set end
        for (int i = 0; i < Depth + 3; i++)
            send_random_triangle(i == Depth + 2);
        // exactly full with set end on the sixteenth
        for (int i = 0; i < Depth; i++)
            send_random_triangle(i == Depth - 1);
        // set end arriving at a full store is itself dropped
        for (int i = 0; i < Depth + 1; i++)
            send_random_triangle(i == Depth);
        drain_results();
    endtask

    task automatic test_random_sets();
        int sent;
        int len;
        sent = 0;
        while (sent < 245)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_random_triangle(i == len - 1);
            sent += len;
        end
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item_tag = '0;
        first_x = '0; first_y = '0; second_x = '0;
        second_y = '0; third_x = '0; third_y = '0;
        set_end = 1'b0;
        error_count = 0;
        timed_out = 1'b0;
        held_count = 0;
        held_overflow = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_extremes();
        test_stable_ties();
        test_overflow();
        test_random_sets();
        if (error_count == 0 && expected_words.size() == 0 && !timed_out)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tps_pkg.sv
rtl/tps_isqrt.sv
rtl/tps_cell.sv
rtl/triangle_perimeter_sorter.sv
dv/tb_triangle_perimeter_sorter.sv
